// File: src/msk_pkg.sv
// ----------------------------------------------------------------------------
// msk_pkg
// Shared types and constants of the merge-split keep-half block.
// ----------------------------------------------------------------------------
package msk_pkg;

  // Width of a key and of the configuration data word.
  localparam int KEY_W = 64;
  localparam int CFG_W = 7;

  // Register index width and the register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_HIGH = 1'b1;

  // Default for the largest block the stores can hold.
  localparam int MAX_BLOCK_DEF = 64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // accept one key transaction
    logic emit;   // pick one key and drive it out
  } msk_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic merge_go;    // the key being loaded completes both blocks
    logic final_pick;  // the current pick is the last key of the half
  } msk_sts_t;

endpackage

// File: src/msk_ram.sv
// ----------------------------------------------------------------------------
// msk_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module msk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/msk_ctrl.sv
// ----------------------------------------------------------------------------
// msk_ctrl
// Controller: accepts key transactions and sequences the merge through a
// read state and a pick state for each emitted key.
// ----------------------------------------------------------------------------
module msk_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  msk_pkg::msk_sts_t sts,
  output msk_pkg::msk_cmd_t cmd,
  output logic              busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start && sts.merge_go) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          state <= sts.final_pick ? S_IDLE : S_READ;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy     = (state != S_IDLE);
  assign cmd.load = start && (state == S_IDLE);
  assign cmd.emit = (state == S_EMIT);

endmodule

// File: src/msk_dp.sv
// ----------------------------------------------------------------------------
// msk_dp
// Datapath: configuration registers, the two key stores with their fill
// counts, and the merge pointers with the compare-and-pick logic.
// ----------------------------------------------------------------------------
module msk_dp #(
  parameter int MAX_BLOCK = msk_pkg::MAX_BLOCK_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [msk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [msk_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          from_partner,
  input  logic signed [msk_pkg::KEY_W-1:0] key,
  input  msk_pkg::msk_cmd_t             cmd,
  output msk_pkg::msk_sts_t             sts,
  output logic signed [msk_pkg::KEY_W-1:0] key_res,
  output logic                          last,
  output logic                          result_valid
);

  localparam int AW = $clog2(MAX_BLOCK);
  localparam int CW = $clog2(MAX_BLOCK + 1);

  logic [msk_pkg::CFG_W-1:0] block_len;
  logic                      keep_high;

  logic [CW-1:0] n;
  logic [CW-1:0] own_count, partner_count;
  logic [CW-1:0] own_count_next, partner_count_next;
  logic          own_fill, partner_fill;

  logic [CW-1:0] take_a, take_b, picked;
  logic [CW-1:0] addr_a_full, addr_b_full;
  logic [AW-1:0] addr_a, addr_b;
  logic [msk_pkg::KEY_W-1:0] a_q, b_q;
  logic          a_done, b_done, pick_own;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_len <= msk_pkg::CFG_W'(MAX_BLOCK);
      keep_high <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        msk_pkg::REG_BLOCK_LEN: block_len <= cfg_data;
        msk_pkg::REG_KEEP_HIGH: keep_high <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective block length, clamped to 1..MAX_BLOCK.
  always_comb begin
    if (block_len == '0) begin
      n = CW'(1);
    end else if (block_len > msk_pkg::CFG_W'(MAX_BLOCK)) begin
      n = CW'(MAX_BLOCK);
    end else begin
      n = block_len[CW-1:0];
    end
  end

  // Fill logic; a key for a block that is already full is dropped.
  assign own_fill           = !from_partner && (own_count < n);
  assign partner_fill       = from_partner && (partner_count < n);
  assign own_count_next     = own_count + CW'(own_fill);
  assign partner_count_next = partner_count + CW'(partner_fill);
  assign sts.merge_go       = (own_count_next >= n) && (partner_count_next >= n);

  // Read addresses: ascending from the bottom, or descending from the top.
  assign addr_a_full = keep_high ? (n - CW'(1) - take_a) : take_a;
  assign addr_b_full = keep_high ? (n - CW'(1) - take_b) : take_b;
  assign addr_a      = addr_a_full[AW-1:0];
  assign addr_b      = addr_b_full[AW-1:0];

  msk_ram #(.WIDTH(msk_pkg::KEY_W), .DEPTH(MAX_BLOCK)) u_own_ram (
    .clk   (clk),
    .we    (cmd.load && own_fill),
    .waddr (own_count[AW-1:0]),
    .wdata (key),
    .raddr (addr_a),
    .rdata (a_q)
  );

  msk_ram #(.WIDTH(msk_pkg::KEY_W), .DEPTH(MAX_BLOCK)) u_partner_ram (
    .clk   (clk),
    .we    (cmd.load && partner_fill),
    .waddr (partner_count[AW-1:0]),
    .wdata (key),
    .raddr (addr_b),
    .rdata (b_q)
  );

  // Pick: ties go to the own block in both directions.
  assign a_done = (take_a == n);
  assign b_done = (take_b == n);
  always_comb begin
    if (b_done) begin
      pick_own = 1'b1;
    end else if (a_done) begin
      pick_own = 1'b0;
    end else if (keep_high) begin
      pick_own = ($signed(b_q) <= $signed(a_q));
    end else begin
      pick_own = ($signed(a_q) <= $signed(b_q));
    end
  end
  assign sts.final_pick = (picked == n - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      own_count     <= '0;
      partner_count <= '0;
      take_a        <= '0;
      take_b        <= '0;
      picked        <= '0;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cmd.load) begin
        if (sts.merge_go) begin
          own_count     <= '0;
          partner_count <= '0;
          take_a        <= '0;
          take_b        <= '0;
          picked        <= '0;
        end else begin
          own_count     <= own_count_next;
          partner_count <= partner_count_next;
        end
      end
      if (cmd.emit) begin
        result_valid <= 1'b1;
        picked       <= picked + CW'(1);
        if (pick_own) begin
          take_a <= take_a + CW'(1);
        end else begin
          take_b <= take_b + CW'(1);
        end
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      key_res <= pick_own ? a_q : b_q;
      last    <= sts.final_pick;
    end
  end

  // A pick always has at least one block with keys left.
  a_pick_has_source: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(a_done && b_done))
    else $error("merge pick with both blocks used up");

  // No result directly follows another; a read state lies between them.
  a_result_spacing: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("results on back-to-back cycles");

  // Every key taken from a block is counted as exactly one pick.
  a_take_balance: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, take_a} + {1'b0, take_b}) == {1'b0, picked})
    else $error("pick count out of step with block pointers");

  // No load lands while a merge is running.
  a_no_load_in_merge: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !cmd.load)
    else $error("load during merge");

endmodule

// File: src/merge_split_keep_half.sv
// ----------------------------------------------------------------------------
// merge_split_keep_half
// Merge-split step of odd-even transposition sort: collects an own and a
// partner block of ascending keys and emits the lower or upper half of
// their union.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                   Handshake
//  --------  --------------------------------------  --------------------------
//  config    cfg_we, cfg_index, cfg_data             write when cfg_we is high
//  input     start, busy, from_partner, key          taken when start && !busy
//  result    result_valid, key_res, last             one cycle, cannot stall
//
// Merge: the key transaction that completes both blocks starts the merge,
// which emits one result per key of the effective block length (block_len
// clamped to 1..MAX_BLOCK), each through a read state for the registered
// read of the two key RAMs and a compare-and-pick state; busy stays high
// for the merge and the last result appears on the cycle busy falls.
// Reset: rst is synchronous and active high; it empties both blocks and
// restores block_len to MAX_BLOCK and keep_high to 0. The RAM contents are
// not cleared; only entries written in the current round are ever read.
// Stalls: the receiver has no way to hold results off, so every result
// transaction completes in the cycle its strobe is high.
// ----------------------------------------------------------------------------
module merge_split_keep_half #(
  parameter int MAX_BLOCK = msk_pkg::MAX_BLOCK_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [msk_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [msk_pkg::CFG_W-1:0]         cfg_data,
  // Key input.
  input  logic                              start,
  output logic                              busy,
  input  logic                              from_partner,
  input  logic signed [msk_pkg::KEY_W-1:0]  key,
  // Results.
  output logic                              result_valid,
  output logic signed [msk_pkg::KEY_W-1:0]  key_res,
  output logic                              last
);

  msk_pkg::msk_cmd_t cmd;
  msk_pkg::msk_sts_t sts;

  // The controller only decides when to load and when to pick; all key
  // storage and comparison sits in the datapath.
  msk_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  msk_dp #(.MAX_BLOCK(MAX_BLOCK)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .from_partner (from_partner),
    .key          (key),
    .cmd          (cmd),
    .sts          (sts),
    .key_res      (key_res),
    .last         (last),
    .result_valid (result_valid)
  );

endmodule
